// ===== design/gfb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gfb_pkg;

    localparam int BLK_W = 10;
    localparam int FCNT_W = 11;

    localparam logic [1:0] CMD_ALLOC  = 2'd0;
    localparam logic [1:0] CMD_FREE   = 2'd1;
    localparam logic [1:0] CMD_FORMAT = 2'd2;
    localparam logic [1:0] CMD_NOP    = 2'd3;

    localparam logic STS_OK       = 1'b0;
    localparam logic STS_NO_SPACE = 1'b1;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [BLK_W-1:0] block_in;
    } t_in_item;

    typedef struct packed {
        logic [BLK_W-1:0]  block_out;
        logic              status;
        logic [FCNT_W-1:0] free_count;
    } t_out_item;

endpackage

`default_nettype wire

// ===== design/gfb_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gfb_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 10
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/grouped_free_block_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Grouped free-block allocator: a stack of up to GROUP free block numbers in a
// RAM with one read and one write port, whose bottom entry names a link block
// holding the next group in a link RAM of NUM_BLOCKS*GROUP words, plus a
// per-block count RAM. A free into a stack that is not full finishes in the
// accept cycle, an allocate that does not empty the stack finishes in S_POP
// after one stack RAM read, an out-of-space allocate in the accept cycle.
// Handing out a link block reloads the stack at one entry per cycle in S_LOAD;
// handing out the last block of the chain finishes in S_LMETA. Freeing into a
// full stack spills it to the link RAM. Format, and the period after reset,
// sweep the count RAM one block per cycle over all NUM_BLOCKS blocks with the
// input stalled. Results go to an output register, so an item can be taken
// while the previous result waits for its transfer.
module grouped_free_block_allocator
    import gfb_pkg::*;
#(
    parameter int NUM_BLOCKS = 1024,
    parameter int GROUP = 50
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_data
);

    localparam int BW  = $clog2(NUM_BLOCKS);
    localparam int SW  = $clog2(GROUP);
    localparam int CW  = $clog2(GROUP + 1);
    localparam int TW  = $clog2(NUM_BLOCKS + 1);
    localparam int LAW = $clog2(NUM_BLOCKS * GROUP);
    localparam int MW  = CW + 1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_POP   = 7'b0000010,
        S_LMETA = 7'b0000100,
        S_LOAD  = 7'b0001000,
        S_SPILL = 7'b0010000,
        S_CLEAR = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [TW-1:0]   r_total, n_total;
    logic [BW-1:0]   r_got, n_got;
    logic [BW-1:0]   r_blk, n_blk;
    logic [LAW-1:0]  r_base, n_base;
    logic [CW-1:0]   r_idx, n_idx;
    logic [SW-1:0]   r_pidx, n_pidx;
    logic            r_pv, n_pv;
    logic            r_flag, n_flag;
    logic [BW-1:0]   r_calc, n_calc;
    logic [BW-1:0]   r_calc_d, n_calc_d;
    logic [BW-1:0]   r_clr, n_clr;
    logic [SW-1:0]   r_grp, n_grp;
    logic            r_fmt, n_fmt;
    t_out_item       r_res, n_res;
    logic            r_ovalid;
    t_out_item       r_out;

    logic            stk_we;
    logic [SW-1:0]   stk_waddr, stk_raddr;
    logic [BW-1:0]   stk_wdata, stk_rdata;
    logic            meta_we;
    logic [BW-1:0]   meta_waddr, meta_raddr;
    logic [MW-1:0]   meta_wdata, meta_rdata;
    logic            lnk_we;
    logic [LAW-1:0]  lnk_waddr, lnk_raddr;
    logic [BW-1:0]   lnk_wdata, lnk_rdata;

    logic            in_xfer;
    logic            out_free;
    logic            fin;
    t_out_item       fin_res;
    logic            load_out;
    logic            blk_ok;
    logic [BW-1:0]   blk_b;
    logic [CW-1:0]   ld_cnt;
    logic [BW-1:0]   rem;
    logic [CW-1:0]   grp_c;
    logic [TW-1:0]   total_dec, total_inc;

    gfb_ram #(.DEPTH(GROUP), .WIDTH(BW)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    gfb_ram #(.DEPTH(NUM_BLOCKS), .WIDTH(MW)) u_meta (
        .i_clk   (i_clk),
        .i_we    (meta_we),
        .i_waddr (meta_waddr),
        .i_wdata (meta_wdata),
        .i_raddr (meta_raddr),
        .o_rdata (meta_rdata)
    );

    gfb_ram #(.DEPTH(NUM_BLOCKS * GROUP), .WIDTH(BW)) u_link (
        .i_clk   (i_clk),
        .i_we    (lnk_we),
        .i_waddr (lnk_waddr),
        .i_wdata (lnk_wdata),
        .i_raddr (lnk_raddr),
        .o_rdata (lnk_rdata)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_free   = !r_ovalid || !i_out_stall;
    assign blk_ok     = ({7'd0, i_in_data.block_in} < 17'(NUM_BLOCKS));
    assign blk_b      = BW'(i_in_data.block_in);
    assign ld_cnt     = meta_rdata[CW-1:0];
    assign rem        = BW'(NUM_BLOCKS - 1) - r_clr;
    assign grp_c      = ({1'b0, rem} >= (BW + 1)'(GROUP)) ? CW'(GROUP) : CW'(rem);
    assign total_dec  = (r_total != '0) ? r_total - 1'b1 : r_total;
    assign total_inc  = (r_total != TW'(NUM_BLOCKS)) ? r_total + 1'b1 : r_total;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_total  = r_total;
        n_got    = r_got;
        n_blk    = r_blk;
        n_base   = r_base;
        n_idx    = r_idx;
        n_pidx   = r_pidx;
        n_pv     = r_pv;
        n_flag   = r_flag;
        n_calc   = r_calc;
        n_calc_d = r_calc_d;
        n_clr    = r_clr;
        n_grp    = r_grp;
        n_fmt    = r_fmt;
        n_res    = r_res;

        stk_we     = 1'b0;
        stk_waddr  = '0;
        stk_wdata  = '0;
        stk_raddr  = '0;
        meta_we    = 1'b0;
        meta_waddr = '0;
        meta_wdata = '0;
        meta_raddr = '0;
        lnk_we     = 1'b0;
        lnk_waddr  = '0;
        lnk_wdata  = '0;
        lnk_raddr  = '0;

        fin       = 1'b0;
        fin_res   = '0;

        unique case (r_state)
            S_IDLE: begin
                stk_raddr = SW'(CW'(GROUP) - r_cnt);
                if (in_xfer) begin
                    unique case (i_in_data.cmd)
                        CMD_ALLOC: begin
                            if (r_cnt == '0) begin
                                fin = 1'b1;
                                fin_res.status = STS_NO_SPACE;
                            end else begin
                                n_state = S_POP;
                            end
                        end
                        CMD_FREE: begin
                            if (!blk_ok) begin
                                fin = 1'b1;
                            end else if (r_cnt == CW'(GROUP)) begin
                                n_blk   = blk_b;
                                n_base  = LAW'(LAW'(blk_b) * LAW'(GROUP));
                                n_idx   = '0;
                                n_pv    = 1'b0;
                                n_state = S_SPILL;
                            end else begin
                                if (r_cnt == '0) begin
                                    meta_we    = 1'b1;
                                    meta_waddr = blk_b;
                                    meta_wdata = '0;
                                end
                                stk_we    = 1'b1;
                                stk_waddr = SW'(CW'(GROUP - 1) - r_cnt);
                                stk_wdata = blk_b;
                                n_cnt     = r_cnt + 1'b1;
                                n_total   = total_inc;
                                fin       = 1'b1;
                            end
                        end
                        CMD_FORMAT: begin
                            n_clr   = '0;
                            n_grp   = '0;
                            n_fmt   = 1'b1;
                            n_state = S_CLEAR;
                        end
                        CMD_NOP: begin
                            fin = 1'b1;
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_POP: begin
                n_got = stk_rdata;
                if (r_cnt == CW'(1)) begin
                    meta_raddr = stk_rdata;
                    n_base     = LAW'(LAW'(stk_rdata) * LAW'(GROUP));
                    n_calc     = stk_rdata + 1'b1;
                    n_state    = S_LMETA;
                end else begin
                    n_cnt   = r_cnt - 1'b1;
                    n_total = total_dec;
                    fin     = 1'b1;
                    fin_res.block_out = BLK_W'(stk_rdata);
                end
            end
            S_LMETA: begin
                meta_we    = 1'b1;
                meta_waddr = r_got;
                meta_wdata = '0;
                n_flag     = meta_rdata[CW];
                n_cnt      = ld_cnt;
                if (ld_cnt == '0) begin
                    n_total = total_dec;
                    fin     = 1'b1;
                    fin_res.block_out = BLK_W'(r_got);
                end else begin
                    n_idx   = CW'(GROUP) - ld_cnt;
                    n_pv    = 1'b0;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (r_idx != CW'(GROUP)) begin
                    lnk_raddr = r_base + LAW'(r_idx);
                    n_calc_d  = r_calc;
                    n_calc    = r_calc + 1'b1;
                    n_pidx    = SW'(r_idx);
                    n_pv      = 1'b1;
                    n_idx     = r_idx + 1'b1;
                end else begin
                    n_pv = 1'b0;
                end
                if (r_pv) begin
                    stk_we    = 1'b1;
                    stk_waddr = r_pidx;
                    stk_wdata = r_flag ? lnk_rdata : r_calc_d;
                end
                if (r_idx == CW'(GROUP) && r_pv) begin
                    n_total = total_dec;
                    fin     = 1'b1;
                    fin_res.block_out = BLK_W'(r_got);
                end
            end
            S_SPILL: begin
                if (r_idx != CW'(GROUP)) begin
                    stk_raddr = SW'(r_idx);
                    n_pidx    = SW'(r_idx);
                    n_pv      = 1'b1;
                    n_idx     = r_idx + 1'b1;
                end else begin
                    n_pv = 1'b0;
                end
                if (r_pv) begin
                    lnk_we    = 1'b1;
                    lnk_waddr = r_base + LAW'(r_pidx);
                    lnk_wdata = stk_rdata;
                end
                if (r_idx == CW'(GROUP) && r_pv) begin
                    meta_we    = 1'b1;
                    meta_waddr = r_blk;
                    meta_wdata = {1'b1, CW'(GROUP)};
                    stk_we     = 1'b1;
                    stk_waddr  = SW'(GROUP - 1);
                    stk_wdata  = r_blk;
                    n_cnt      = CW'(1);
                    n_total    = total_inc;
                    fin        = 1'b1;
                end
            end
            S_CLEAR: begin
                meta_we    = 1'b1;
                meta_waddr = r_clr;
                meta_wdata = {1'b0, (r_grp == SW'(GROUP - 1)) ? grp_c : CW'(0)};
                if ({1'b0, r_clr} < (BW + 1)'(GROUP)) begin
                    stk_we    = 1'b1;
                    stk_waddr = SW'(r_clr);
                    stk_wdata = r_clr;
                end
                n_clr = r_clr + 1'b1;
                n_grp = (r_grp == SW'(GROUP - 1)) ? '0 : r_grp + 1'b1;
                if (r_clr == BW'(NUM_BLOCKS - 1)) begin
                    n_cnt   = CW'(GROUP);
                    n_total = TW'(NUM_BLOCKS);
                    n_fmt   = 1'b0;
                    n_state = S_IDLE;
                    fin     = r_fmt;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        fin_res.free_count = FCNT_W'(n_total);
        if (fin) begin
            n_res   = fin_res;
            n_state = out_free ? S_IDLE : S_DONE;
        end
    end

    assign load_out = (fin || r_state == S_DONE) && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_cnt    <= CW'(GROUP);
            r_total  <= TW'(NUM_BLOCKS);
            r_idx    <= '0;
            r_pv     <= 1'b0;
            r_clr    <= '0;
            r_grp    <= '0;
            r_fmt    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_total <= n_total;
            r_idx   <= n_idx;
            r_pv    <= n_pv;
            r_clr   <= n_clr;
            r_grp   <= n_grp;
            r_fmt   <= n_fmt;
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_got    <= n_got;
        r_blk    <= n_blk;
        r_base   <= n_base;
        r_pidx   <= n_pidx;
        r_flag   <= n_flag;
        r_calc   <= n_calc;
        r_calc_d <= n_calc_d;
        r_res    <= n_res;
        if (load_out) begin
            r_out <= (r_state == S_DONE) ? r_res : fin_res;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(GROUP))
        else $error("stack count above group size");

    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= TW'(NUM_BLOCKS))
        else $error("free total above block count");

    a_format_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in_data.cmd == CMD_FORMAT) |=> (r_state == S_CLEAR))
        else $error("format did not start the sweep");

    a_spill_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SPILL && r_idx == CW'(GROUP) && r_pv) |=> (r_cnt == CW'(1)))
        else $error("spill did not leave one entry on the stack");

    a_no_space_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == STS_NO_SPACE) |-> (o_out_data.block_out == '0))
        else $error("out-of-space result carries a block");

endmodule

`default_nettype wire
